[rtl/core/ppds_pkg.sv]
// Shared types and constants for the position PID differential steering block.
// Holds register indexes, field widths, FSM and command types, and the target limiter.
// No dependencies.
package ppds_pkg;

    // Field widths
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = 16;
    localparam int SPEED_W  = 16;
    localparam int TGT_W    = 15;
    localparam int SUM_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int TSUM_W  = 26;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_UPPER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_LOWER     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_PER_UNIT = 3'd5;

    // Reset values of the configuration registers
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN      = 16'sd256;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN     = 16'sd0;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN     = 16'sd0;
    localparam logic [GAIN_W-1:0] RST_CORR_UPPER     = 16'sd3200;
    localparam logic [GAIN_W-1:0] RST_CORR_LOWER     = -16'sd3200;
    localparam logic [GAIN_W-1:0] RST_SPEED_PER_UNIT = 16'd33;

    localparam logic [TGT_W-1:0] TGT_MAX = 15'h7FFF;

    // Item request types
    localparam logic REQ_STEP  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_SUM,
        ST_SCALE,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MUL_P,
        MUL_I,
        MUL_D,
        MUL_S
    } mul_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     load_item;
        logic     clear_item;
        mul_sel_t mul_sel;
        logic     acc_init;
        logic     acc_add;
        logic     corr_load;
        logic     out_load;
    } dp_cmd_t;

    // Limit a signed wheel target to 0..32767
    function automatic logic [TGT_W-1:0] sat_target(input logic signed [TSUM_W-1:0] v);
        logic [TGT_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed({{(TSUM_W-TGT_W){1'b0}}, TGT_MAX}))
        begin
            r = TGT_MAX;
        end
        else
        begin
            r = v[TGT_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/ppds_ctrl.sv]
// Sequencing FSM for the position PID steering block.
// Drives the datapath command struct and the input/output handshakes.
// Depends on ppds_pkg.
module ppds_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    output logic              out_valid,
    input  logic              out_ready,
    output ppds_pkg::dp_cmd_t cmd
);
    import ppds_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    // Output slot can take a new item when empty or being drained
    assign slot_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (req_type == REQ_CLEAR) ? ST_FINISH : ST_MUL_P;
                end
            end
            ST_MUL_P:  state_next = ST_MUL_I;
            ST_MUL_I:  state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_SUM;
            ST_SUM:    state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = MUL_P;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.load_item  = in_valid;
                cmd.clear_item = in_valid && (req_type == REQ_CLEAR);
            end
            ST_MUL_P:  cmd.mul_sel = MUL_P;
            ST_MUL_I:
            begin
                cmd.mul_sel  = MUL_I;
                cmd.acc_init = 1'b1;
            end
            ST_MUL_D:
            begin
                cmd.mul_sel = MUL_D;
                cmd.acc_add = 1'b1;
            end
            ST_SUM:    cmd.corr_load = 1'b1;
            ST_SCALE:  cmd.mul_sel = MUL_S;
            ST_FINISH:
            begin
                // Keep the speed product in place while the output slot is busy
                cmd.mul_sel  = MUL_S;
                cmd.out_load = slot_free;
            end
            default:   cmd.mul_sel = MUL_P;
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A step item always starts with the proportional multiply
    a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == REQ_STEP) |=> state_reg == ST_MUL_P)
        else $error("step item did not start the multiply sequence");

    // A new result only appears out of the finish state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside the finish state");

    // A full, stalled output slot holds the finished item back
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && out_valid_reg && !out_ready |=> state_reg == ST_FINISH)
        else $error("finished item overwrote a waiting result");

endmodule

[rtl/core/ppds_dp.sv]
// Datapath for the position PID steering block: configuration registers,
// PID state, shared 17x33 multiplier, accumulator, limiters and output register.
// Depends on ppds_pkg.
module ppds_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ppds_pkg::dp_cmd_t                      cmd,
    input  logic                                   cfg_we,
    input  logic [ppds_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ppds_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [ppds_pkg::ERR_W-1:0]      sensor_err,
    input  logic signed [ppds_pkg::SPEED_W-1:0]    base_speed,
    output logic signed [ppds_pkg::GAIN_W-1:0]     correction,
    output logic [ppds_pkg::TGT_W-1:0]             left_target,
    output logic [ppds_pkg::TGT_W-1:0]             right_target
);
    import ppds_pkg::*;

    // Configuration
    logic signed [GAIN_W-1:0]  kp_reg, ki_reg, kd_reg, upper_reg, lower_reg;
    logic [GAIN_W-1:0]         spu_reg;

    // PID state and item registers
    logic signed [SUM_W-1:0]   err_sum_reg, err_sum_next;
    logic signed [ERR_W-1:0]   prev_err_reg, prev_err_next;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [SPEED_W-1:0] base_reg;
    logic signed [ERR_W:0]     delta_reg, delta_next;
    logic                      clr_reg;

    // Arithmetic
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0]  raw_sum;
    logic signed [PROD_W-1:0]  raw_shift;
    logic signed [PROD_W-1:0]  upper_ext, lower_ext;
    logic signed [GAIN_W-1:0]  corr_reg, corr_next;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [PROD_W-1:0]  diff_full;
    logic signed [TSUM_W-1:0]  diff_t, base_t;

    // Output register
    logic signed [GAIN_W-1:0]  corr_out_reg, corr_out_next;
    logic [TGT_W-1:0]          left_reg, left_next;
    logic [TGT_W-1:0]          right_reg, right_next;

    // Configuration writes; indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= RST_PROP_GAIN;
            ki_reg    <= RST_INTEG_GAIN;
            kd_reg    <= RST_DERIV_GAIN;
            upper_reg <= RST_CORR_UPPER;
            lower_reg <= RST_CORR_LOWER;
            spu_reg   <= RST_SPEED_PER_UNIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROP_GAIN:      kp_reg    <= cfg_data;
                CFG_INTEG_GAIN:     ki_reg    <= cfg_data;
                CFG_DERIV_GAIN:     kd_reg    <= cfg_data;
                CFG_CORR_UPPER:     upper_reg <= cfg_data;
                CFG_CORR_LOWER:     lower_reg <= cfg_data;
                CFG_SPEED_PER_UNIT: spu_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Error sum update with 32-bit saturation (cleared on a zero error), delta and last error
    always_comb
    begin
        err_sum_next  = err_sum_reg;
        prev_err_next = prev_err_reg;
        delta_next    = delta_reg;
        sum_wide      = {err_sum_reg[SUM_W-1], err_sum_reg}
                      + {{(SUM_W+1-ERR_W){sensor_err[ERR_W-1]}}, sensor_err};
        if (cmd.load_item)
        begin
            if (cmd.clear_item)
            begin
                err_sum_next  = '0;
                prev_err_next = '0;
            end
            else
            begin
                if (sensor_err == '0)
                begin
                    err_sum_next = '0;
                end
                else if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                begin
                    err_sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                   : {1'b0, {(SUM_W-1){1'b1}}};
                end
                else
                begin
                    err_sum_next = sum_wide[SUM_W-1:0];
                end
                delta_next    = {sensor_err[ERR_W-1], sensor_err}
                              - {prev_err_reg[ERR_W-1], prev_err_reg};
                prev_err_next = sensor_err;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_sum_reg  <= '0;
            prev_err_reg <= '0;
        end
        else
        begin
            err_sum_reg  <= err_sum_next;
            prev_err_reg <= prev_err_next;
        end
    end

    // Latch the item payload
    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        if (cmd.load_item)
        begin
            err_reg  <= sensor_err;
            base_reg <= base_speed;
            clr_reg  <= cmd.clear_item;
        end
    end

    // Select operands of the shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_P:
            begin
                mul_a = {kp_reg[GAIN_W-1], kp_reg};
                mul_b = {{(MUL_B_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
            end
            MUL_I:
            begin
                mul_a = {ki_reg[GAIN_W-1], ki_reg};
                mul_b = {err_sum_reg[SUM_W-1], err_sum_reg};
            end
            MUL_D:
            begin
                mul_a = {kd_reg[GAIN_W-1], kd_reg};
                mul_b = {{(MUL_B_W-ERR_W-1){delta_reg[ERR_W]}}, delta_reg};
            end
            MUL_S:
            begin
                mul_a = {corr_reg[GAIN_W-1], corr_reg};
                mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, spu_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Accumulate PID terms, then floor-shift and limit (upper first, lower last)
    always_comb
    begin
        upper_ext = {{(PROD_W-GAIN_W){upper_reg[GAIN_W-1]}}, upper_reg};
        lower_ext = {{(PROD_W-GAIN_W){lower_reg[GAIN_W-1]}}, lower_reg};
        raw_sum   = acc_reg + prod_reg;
        raw_shift = raw_sum >>> 8;
        acc_next  = acc_reg;
        if (cmd.acc_init)
        begin
            acc_next = prod_reg;
        end
        else if (cmd.acc_add)
        begin
            acc_next = raw_sum;
        end
        corr_next = corr_reg;
        if (cmd.load_item)
        begin
            corr_next = '0;
        end
        else if (cmd.corr_load)
        begin
            if (raw_shift < lower_ext)
            begin
                corr_next = lower_reg;
            end
            else if (raw_shift > upper_ext)
            begin
                corr_next = (upper_reg < lower_reg) ? lower_reg : upper_reg;
            end
            else
            begin
                corr_next = raw_shift[GAIN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        corr_reg <= corr_next;
    end

    // Wheel targets from the scaled correction
    always_comb
    begin
        diff_full     = prod_reg >>> 8;
        diff_t        = diff_full[TSUM_W-1:0];
        base_t        = {{(TSUM_W-SPEED_W){base_reg[SPEED_W-1]}}, base_reg};
        corr_out_next = corr_out_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        if (cmd.out_load)
        begin
            if (clr_reg)
            begin
                corr_out_next = '0;
                left_next     = '0;
                right_next    = '0;
            end
            else
            begin
                corr_out_next = corr_reg;
                left_next     = sat_target(base_t - diff_t);
                right_next    = sat_target(base_t + diff_t);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        corr_out_reg <= corr_out_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
    end

    assign correction   = corr_out_reg;
    assign left_target  = left_reg;
    assign right_target = right_reg;

    // The lower limit is applied last, so a limited correction never falls below it
    a_corr_floor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.corr_load && !cmd.load_item |=> corr_reg >= $past(lower_reg))
        else $error("correction below lower limit");

    // A clear item loads an all-zero result
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && clr_reg |=> corr_out_reg == '0 && left_reg == '0 && right_reg == '0)
        else $error("clear item gave a nonzero result");

    // A clear item empties the error sum and the last error
    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item && cmd.clear_item |=> err_sum_reg == '0 && prev_err_reg == '0)
        else $error("clear item left PID state behind");

endmodule

[rtl/core/position_pid_differential_steering_top.sv]
// Position PID loop of a line-following differential steering controller.
// Top level; instantiates ppds_ctrl and ppds_dp, uses ppds_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries req_type, sensor_err and
//   base_speed. A step item runs the PID and yields correction plus left and
//   right wheel targets; a clear item zeroes the error sum and last error and
//   yields an all-zero result. Every item gives exactly one result on the
//   output channel (out_valid/out_ready).
//   A step item steps through MUL_P, MUL_I, MUL_D, SUM, SCALE and FINISH: the
//   four multiplies (P, I, D and speed scaling) share one 17x33 multiplier
//   in turn, with the sum and limit in SUM and the output load in FINISH. A
//   clear item goes straight to FINISH. One item is in work at a time; the
//   next is accepted the cycle after the result loads.
//   If the receiver stalls, the result holds in the output register; a
//   following item is still accepted and runs until it waits for that
//   register to drain.
//   Reset (rst_n low, asynchronous) loads the default gains and limits,
//   clears the error sum and last error, and empties the output.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//   make them only while the block is idle.
module position_pid_differential_steering_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [ppds_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ppds_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   req_type,
    input  logic signed [ppds_pkg::ERR_W-1:0]      sensor_err,
    input  logic signed [ppds_pkg::SPEED_W-1:0]    base_speed,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [ppds_pkg::GAIN_W-1:0]     correction,
    output logic [ppds_pkg::TGT_W-1:0]             left_target,
    output logic [ppds_pkg::TGT_W-1:0]             right_target
);
    import ppds_pkg::*;

    dp_cmd_t cmd;

    // Sequencer
    ppds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Arithmetic and storage
    ppds_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sensor_err   (sensor_err),
        .base_speed   (base_speed),
        .correction   (correction),
        .left_target  (left_target),
        .right_target (right_target)
    );

endmodule
